/* src/matrix_multiply_macros.svh */
// Assertion macros for the matrix multiply block.
// Included by the top level; the bodies are empty when SYNTHESIS is defined.
`ifndef MATRIX_MULTIPLY_MACROS_SVH
`define MATRIX_MULTIPLY_MACROS_SVH
`ifndef SYNTHESIS
`define MM_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("matrix_multiply: same-cycle check failed");
`define MM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("matrix_multiply: next-cycle check failed");
`else
`define MM_ASSERT_IMPL(lbl, ante, cons)
`define MM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* src/mm_pkg.sv */
// Shared constants for the matrix multiply block: port widths,
// configuration register indexes and reset values. No dependencies.
package mm_pkg;

  localparam int ELEM_IN_W  = 16;
  localparam int PRODUCT_W  = 35;
  localparam int OUT_IDX_W  = 3;
  localparam int CFG_W      = 4;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_B = 2'd2;

  localparam logic [CFG_W-1:0] CFG_DIM_RESET = 4'd8;

endpackage

/* src/mm_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Used for the matrix stores of the matrix multiply block. No dependencies.
module mm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                   clk_i,
  input  logic                                   wr_en_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]                       wr_data_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]                       rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

/* src/matrix_multiply.sv */
// Matrix multiply: loads A (rows_a x inner) then B (inner x cols_b), one element a request,
// then streams C = A*B in row-major order through one shared multiply-accumulate unit.
// Load: one element per cycle. Each product element goes through read, multiply,
// accumulate, then output register; the input stalls from the last B element until the
// final product element is in the output register. Reset clears the sequencer and sets all
// dimension registers to 8; the matrix stores are undefined until written.
`include "matrix_multiply_macros.svh"

module matrix_multiply #(
  parameter int MAX_DIM      = 8,
  parameter int ELEMENT_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [mm_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [mm_pkg::CFG_W-1:0]             cfg_data_i,
  input  logic                                 element_valid_i,
  output logic                                 element_stall_o,
  input  logic signed [mm_pkg::ELEM_IN_W-1:0]  element_value_i,
  output logic                                 product_valid_o,
  input  logic                                 product_stall_i,
  output logic signed [mm_pkg::PRODUCT_W-1:0]  product_value_o,
  output logic [mm_pkg::OUT_IDX_W-1:0]         row_index_o,
  output logic [mm_pkg::OUT_IDX_W-1:0]         col_index_o,
  output logic                                 last_of_run_o
);

  import mm_pkg::*;

  localparam int EW    = ELEMENT_BITS;
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int MW    = 2 * EW;
  localparam int PW    = (MW > PRODUCT_W) ? MW : PRODUCT_W;

  localparam logic [1:0] S_LOAD  = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;

  function automatic logic [IW-1:0] last_idx(input logic [CFG_W-1:0] raw);
    int r;
    r = int'(raw);
    if (r < 1) r = 1;
    if (r > MAX_DIM) r = MAX_DIM;
    return IW'(r - 1);
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic [IW-1:0] r, input logic [IW-1:0] c);
    return AW'(int'(r) * MAX_DIM + int'(c));
  endfunction

  logic [CFG_W-1:0] rows_a_q, inner_q, cols_b_q;
  logic [1:0]       state_q, state_d;
  logic             phase_b_q, phase_b_d;
  logic [IW-1:0]    ld_row_q, ld_row_d, ld_col_q, ld_col_d;
  logic [IW-1:0]    i_q, i_d, j_q, j_d, k_q, k_d;
  logic             rd_v_q, rd_first_q, mul_v_q, mul_first_q;
  logic signed [MW-1:0]        prod_q;
  logic signed [PRODUCT_W-1:0] acc_q;
  logic             out_valid_q, out_valid_d, out_last_q;
  logic signed [PRODUCT_W-1:0] out_value_q;
  logic [IW-1:0]    out_row_q, out_col_q;

  logic [IW-1:0]    m_last, p_last, n_last;
  logic             cfg_hit, in_accept, ld_row_end, ld_col_end, last_b;
  logic             issue, drain_done, out_free, out_load;
  logic [EW+ELEM_IN_W-1:0] elem_ext;
  logic [EW-1:0]    elem;
  logic [EW-1:0]    a_rdata, b_rdata;
  logic signed [PW-1:0] prod_ext;

  assign m_last = last_idx(rows_a_q);
  assign p_last = last_idx(inner_q);
  assign n_last = last_idx(cols_b_q);

  assign cfg_hit = cfg_we_i && (cfg_index_i == CFG_ROWS_A || cfg_index_i == CFG_INNER ||
                                cfg_index_i == CFG_COLS_B);

  assign element_stall_o = (state_q != S_LOAD);
  assign in_accept       = element_valid_i && !element_stall_o;

  assign elem_ext = {{EW{1'b0}}, element_value_i};
  assign elem     = elem_ext[EW-1:0];

  assign ld_col_end = phase_b_q ? (ld_col_q == n_last) : (ld_col_q == p_last);
  assign ld_row_end = phase_b_q ? (ld_row_q == p_last) : (ld_row_q == m_last);
  assign last_b     = phase_b_q && ld_row_end && ld_col_end;

  assign issue      = (state_q == S_ISSUE);
  assign drain_done = (state_q == S_DRAIN) && !rd_v_q && !mul_v_q;
  assign out_free   = !out_valid_q || !product_stall_i;
  assign out_load   = drain_done && out_free;

  mm_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_store_a (
    .clk_i     (clk_i),
    .wr_en_i   (in_accept && !phase_b_q),
    .wr_addr_i (addr_of(ld_row_q, ld_col_q)),
    .wr_data_i (elem),
    .rd_addr_i (addr_of(i_q, k_q)),
    .rd_data_o (a_rdata)
  );

  mm_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_store_b (
    .clk_i     (clk_i),
    .wr_en_i   (in_accept && phase_b_q),
    .wr_addr_i (addr_of(ld_row_q, ld_col_q)),
    .wr_data_i (elem),
    .rd_addr_i (addr_of(k_q, j_q)),
    .rd_data_o (b_rdata)
  );

  always_comb begin
    state_d     = state_q;
    phase_b_d   = phase_b_q;
    ld_row_d    = ld_row_q;
    ld_col_d    = ld_col_q;
    i_d         = i_q;
    j_d         = j_q;
    k_d         = k_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !product_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_LOAD: begin
        if (cfg_hit) begin
          phase_b_d = 1'b0;
          ld_row_d  = '0;
          ld_col_d  = '0;
        end else if (in_accept) begin
          if (last_b) begin
            phase_b_d = 1'b0;
            ld_row_d  = '0;
            ld_col_d  = '0;
            i_d       = '0;
            j_d       = '0;
            k_d       = '0;
            state_d   = S_ISSUE;
          end else if (ld_col_end) begin
            ld_col_d = '0;
            if (ld_row_end) begin
              ld_row_d  = '0;
              phase_b_d = 1'b1;
            end else begin
              ld_row_d = ld_row_q + 1'b1;
            end
          end else begin
            ld_col_d = ld_col_q + 1'b1;
          end
        end
      end
      S_ISSUE: begin
        if (k_q == p_last) begin
          k_d     = '0;
          state_d = S_DRAIN;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      S_DRAIN: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = S_ISSUE;
          if (j_q == n_last) begin
            j_d = '0;
            if (i_q == m_last) begin
              i_d     = '0;
              state_d = S_LOAD;
            end else begin
              i_d = i_q + 1'b1;
            end
          end else begin
            j_d = j_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q    <= CFG_DIM_RESET;
      inner_q     <= CFG_DIM_RESET;
      cols_b_q    <= CFG_DIM_RESET;
      state_q     <= S_LOAD;
      phase_b_q   <= 1'b0;
      ld_row_q    <= '0;
      ld_col_q    <= '0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      rd_v_q      <= 1'b0;
      rd_first_q  <= 1'b0;
      mul_v_q     <= 1'b0;
      mul_first_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_index_i == CFG_ROWS_A) rows_a_q <= cfg_data_i;
      if (cfg_we_i && cfg_index_i == CFG_INNER)  inner_q  <= cfg_data_i;
      if (cfg_we_i && cfg_index_i == CFG_COLS_B) cols_b_q <= cfg_data_i;
      state_q     <= state_d;
      phase_b_q   <= phase_b_d;
      ld_row_q    <= ld_row_d;
      ld_col_q    <= ld_col_d;
      i_q         <= i_d;
      j_q         <= j_d;
      k_q         <= k_d;
      rd_v_q      <= issue;
      rd_first_q  <= issue && (k_q == '0);
      mul_v_q     <= rd_v_q;
      mul_first_q <= rd_first_q;
      out_valid_q <= out_valid_d;
    end
  end

  assign prod_ext = PW'(prod_q);

  always_ff @(posedge clk_i) begin
    if (rd_v_q) begin
      prod_q <= MW'($signed(a_rdata) * $signed(b_rdata));
    end
    if (mul_v_q) begin
      acc_q <= mul_first_q ? prod_ext[PRODUCT_W-1:0] : acc_q + prod_ext[PRODUCT_W-1:0];
    end
    if (out_load) begin
      out_value_q <= acc_q;
      out_row_q   <= i_q;
      out_col_q   <= j_q;
      out_last_q  <= (i_q == m_last) && (j_q == n_last);
    end
  end

  assign product_valid_o = out_valid_q;
  assign product_value_o = out_value_q;
  assign row_index_o     = OUT_IDX_W'(out_row_q);
  assign col_index_o     = OUT_IDX_W'(out_col_q);
  assign last_of_run_o   = out_last_q;

  `MM_ASSERT_IMPL(a_mac_in_compute, mul_v_q, (state_q == S_ISSUE || state_q == S_DRAIN))
  `MM_ASSERT_IMPL(a_load_pipe_empty, (state_q == S_LOAD), (!rd_v_q && !mul_v_q))
  `MM_ASSERT_IMPL(a_k_in_range, (state_q == S_ISSUE), (k_q <= p_last))
  `MM_ASSERT_NEXT(a_result_loaded, out_load, product_valid_o)

endmodule

/* bench/matrix_multiply_tb.sv */
// Self-checking bench for matrix_multiply: streams A and B elements, predicts every
// product element in row-major order and checks value, indexes and the last flag.
// Depends on mm_pkg and the matrix_multiply top level only.
module matrix_multiply_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mm_pkg::*;

  localparam int DIM_MAX        = 8;
  localparam int STORE_DEPTH    = DIM_MAX * DIM_MAX;
  localparam int SETTLE_CYCLES  = 16;
  localparam int DRAIN_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_TARGET  = 185;
  localparam int CALM_AFTER     = 150;

  typedef struct packed {
    logic [PRODUCT_W-1:0] value;
    logic [OUT_IDX_W-1:0] row;
    logic [OUT_IDX_W-1:0] col;
    logic                 last;
  } product_t;

  logic                         clk_i           = 1'b0;
  logic                         rst_ni          = 1'b0;
  logic                         cfg_we_i        = 1'b0;
  logic [CFG_IDX_W-1:0]         cfg_index_i     = '0;
  logic [CFG_W-1:0]             cfg_data_i      = '0;
  logic                         element_valid_i = 1'b0;
  logic                         element_stall_o;
  logic signed [ELEM_IN_W-1:0]  element_value_i = '0;
  logic                         product_valid_o;
  logic                         product_stall_i = 1'b0;
  logic signed [PRODUCT_W-1:0]  product_value_o;
  logic [OUT_IDX_W-1:0]         row_index_o;
  logic [OUT_IDX_W-1:0]         col_index_o;
  logic                         last_of_run_o;

  logic signed [ELEM_IN_W-1:0]  queued_elements[$];
  product_t                     pending_products[$];

  logic signed [ELEM_IN_W-1:0]  a_store[STORE_DEPTH];
  logic signed [ELEM_IN_W-1:0]  b_store[STORE_DEPTH];
  int                           load_count;
  logic [CFG_W-1:0]             rows_cfg;
  logic [CFG_W-1:0]             inner_cfg;
  logic [CFG_W-1:0]             cols_cfg;

  int       mismatches   = 0;
  int       items_sent   = 0;
  bit       idling_on    = 1'b1;
  int       send_gap     = 0;
  int       stall_left   = 0;
  int       quiet_cycles = 0;
  product_t want;

  matrix_multiply dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .element_valid_i (element_valid_i),
    .element_stall_o (element_stall_o),
    .element_value_i (element_value_i),
    .product_valid_o (product_valid_o),
    .product_stall_i (product_stall_i),
    .product_value_o (product_value_o),
    .row_index_o     (row_index_o),
    .col_index_o     (col_index_o),
    .last_of_run_o   (last_of_run_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic int clamp_dim(input logic [CFG_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > DIM_MAX) return DIM_MAX;
    return int'(raw);
  endfunction

  function automatic int load_size();
    return clamp_dim(rows_cfg) * clamp_dim(inner_cfg) +
           clamp_dim(inner_cfg) * clamp_dim(cols_cfg);
  endfunction

  function automatic logic [ELEM_IN_W-1:0] pick_element();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3:       return 16'hffff;
      default: return ELEM_IN_W'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_dim();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return CFG_W'($urandom_range(DIM_MAX + 1, 15));
    if (r < 7) return CFG_W'(1);
    if (r < 12) return CFG_W'(DIM_MAX);
    return CFG_W'($urandom_range(2, DIM_MAX - 1));
  endfunction

  // Store one accepted element; the last element of B yields the whole product.
  task automatic absorb_element(input logic signed [ELEM_IN_W-1:0] elem);
    int       m, p, n, e, i, j, k;
    longint   acc;
    product_t r;
    m = clamp_dim(rows_cfg);
    p = clamp_dim(inner_cfg);
    n = clamp_dim(cols_cfg);
    e = load_count;
    if (e < m * p) begin
      a_store[(e / p) * DIM_MAX + e % p] = elem;
      load_count = e + 1;
      return;
    end
    e -= m * p;
    if (e >= p * n) begin
      load_count = 0;
      return;
    end
    b_store[(e / n) * DIM_MAX + e % n] = elem;
    if (e + 1 < p * n) begin
      load_count++;
      return;
    end
    load_count = 0;
    for (i = 0; i < m; i++) begin
      for (j = 0; j < n; j++) begin
        acc = 0;
        for (k = 0; k < p; k++) begin
          acc += longint'(a_store[i * DIM_MAX + k]) * longint'(b_store[k * DIM_MAX + j]);
        end
        r.value = acc[PRODUCT_W-1:0];
        r.row   = OUT_IDX_W'(i);
        r.col   = OUT_IDX_W'(j);
        r.last  = (i + 1 == m) && (j + 1 == n);
        pending_products.push_back(r);
      end
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatches++;
  endtask

  task automatic write_dim(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    case (idx)
      CFG_ROWS_A: rows_cfg  = val;
      CFG_INNER:  inner_cfg = val;
      CFG_COLS_B: cols_cfg  = val;
      default: ;
    endcase
    load_count = 0;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic queue_value(input logic [ELEM_IN_W-1:0] v);
    queued_elements.push_back(v);
    items_sent++;
    if (items_sent >= CALM_AFTER) idling_on = 1'b0;
  endtask

  task automatic queue_elements(input int count);
    repeat (count) queue_value(pick_element());
  endtask

  // Hold until every request is taken and every product has come back.
  task automatic settle();
    while (queued_elements.size() != 0 || element_valid_i || pending_products.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      element_valid_i <= 1'b0;
      send_gap = 0;
    end else begin
      if (element_valid_i && !element_stall_o) absorb_element(element_value_i);
      if (!element_valid_i || !element_stall_o) begin
        if (send_gap > 0) begin
          send_gap--;
          element_valid_i <= 1'b0;
        end else if (idling_on && queued_elements.size() != 0 && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(1, 18) - 1;
          element_valid_i <= 1'b0;
        end else if (queued_elements.size() != 0) begin
          element_valid_i <= 1'b1;
          element_value_i <= queued_elements.pop_front();
        end else begin
          element_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      product_stall_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (product_valid_o && !product_stall_i) begin
        if (pending_products.size() == 0) begin
          report_mismatch($sformatf("unexpected product row %0d col %0d value %0d",
                                    row_index_o, col_index_o, product_value_o));
        end else begin
          want = pending_products.pop_front();
          if (product_value_o !== want.value)
            report_mismatch($sformatf("product_value %0d, want %0d at row %0d col %0d",
                                      product_value_o, $signed(want.value), want.row, want.col));
          if (row_index_o !== want.row)
            report_mismatch($sformatf("row_index %0d, want %0d", row_index_o, want.row));
          if (col_index_o !== want.col)
            report_mismatch($sformatf("col_index %0d, want %0d", col_index_o, want.col));
          if (last_of_run_o !== want.last)
            report_mismatch($sformatf("last_of_run %0b, want %0b at row %0d col %0d",
                                      last_of_run_o, want.last, want.row, want.col));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        product_stall_i <= 1'b1;
      end else if (idling_on && $urandom_range(0, 15) == 0) begin
        stall_left = $urandom_range(1, 18) - 1;
        product_stall_i <= 1'b1;
      end else begin
        product_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (element_valid_i && !element_stall_o) ||
        (product_valid_o && !product_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("matrix_multiply regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [CFG_W-1:0] dim_r, dim_k, dim_c;
    bit               first_phase;
    for (int s = 0; s < STORE_DEPTH; s++) begin
      a_store[s] = '0;
      b_store[s] = '0;
    end
    rows_cfg   = CFG_DIM_RESET;
    inner_cfg  = CFG_DIM_RESET;
    cols_cfg   = CFG_DIM_RESET;
    load_count = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // 1x1 products at the signed extremes
    write_dim(CFG_ROWS_A, 4'd1);
    write_dim(CFG_INNER, 4'd1);
    write_dim(CFG_COLS_B, 4'd1);
    queue_value(16'h8000);
    queue_value(16'h8000);
    queue_value(16'h7fff);
    queue_value(16'h8000);
    settle();

    // zero and oversized dimensions clamp; largest possible sum
    write_dim(CFG_ROWS_A, 4'd0);
    write_dim(CFG_INNER, 4'd15);
    write_dim(CFG_COLS_B, 4'd0);
    repeat (16) queue_value(16'h8000);
    settle();

    // abort a partial load with a register write
    write_dim(CFG_ROWS_A, 4'd2);
    write_dim(CFG_INNER, 4'd1);
    write_dim(CFG_COLS_B, 4'd2);
    queue_elements(3);
    settle();
    write_dim(CFG_INNER, 4'd1);
    queue_elements(4);
    settle();

    first_phase = 1'b1;
    while (items_sent < RANDOM_TARGET) begin
      if (!first_phase && load_size() > 1 && $urandom_range(0, 4) == 0) begin
        queue_elements($urandom_range(1, load_size() - 1));
        settle();
      end
      if (first_phase) begin
        dim_r = CFG_W'(DIM_MAX);
        dim_k = CFG_W'(1);
        dim_c = CFG_W'(DIM_MAX);
        first_phase = 1'b0;
      end else begin
        dim_r = pick_dim();
        dim_k = pick_dim();
        dim_c = pick_dim();
        if (clamp_dim(dim_r) * clamp_dim(dim_k) + clamp_dim(dim_k) * clamp_dim(dim_c) > 80)
          dim_k = CFG_W'($urandom_range(1, 2));
      end
      write_dim(CFG_ROWS_A, dim_r);
      write_dim(CFG_INNER, dim_k);
      write_dim(CFG_COLS_B, dim_c);
      repeat ($urandom_range(1, 3)) queue_elements(load_size());
      settle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_products.size() != 0)
      report_mismatch($sformatf("%0d products never arrived", pending_products.size()));
    if (mismatches == 0) begin
      $display("matrix_multiply regression: pass");
    end else begin
      $display("matrix_multiply regression: fail");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+src
src/mm_pkg.sv
src/mm_ram.sv
src/matrix_multiply.sv
bench/matrix_multiply_tb.sv
